@@ rtl/cfw_pkg.sv @@
// ----------------------------------------------------------------------------
// cfw_pkg
// Shared constants, types and helpers of the case folding word filter.
// ----------------------------------------------------------------------------
package cfw_pkg;

   // longest word held in the cell row
   localparam int MAX_WORD  = 30;
   localparam int LEN_W     = $clog2(MAX_WORD + 1);
   localparam int CMP_W     = LEN_W + 5;

   // configured word storage
   localparam int CFG_CHARS = 30;
   localparam int CFG_BITS  = CFG_CHARS * 8;

   // configuration port
   localparam int PADDR_W   = 6;
   localparam int PDATA_W   = 64;

   localparam logic [7:0] FOLD_BIT   = 8'h20;
   localparam logic [7:0] SPACE_BYTE = 8'h20;

   // per-cycle command to the cell row
   typedef struct packed {
      logic append;
      logic shift;
      logic clear;
   } cell_ctl_type;

   // whitespace test
   function automatic logic is_sep(input logic [7:0] b);
      return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0d);
   endfunction

   // character idx of the configured word, zero past its end
   function automatic logic [7:0] cfg_char(input logic [CFG_BITS-1:0] chars,
                                           input logic [LEN_W-1:0]    idx);
      logic [7:0] ch;
      ch = '0;
      for (int i = 0; i < CFG_CHARS; i++) begin
         if (CMP_W'(idx) == CMP_W'(i)) begin
            ch = chars[i*8 +: 8];
         end
      end
      return ch;
   endfunction

endpackage

@@ rtl/case_folding_word_filter.sv @@
// ----------------------------------------------------------------------------
// case_folding_word_filter
// Drops every whitespace-delimited word equal, case folded, to a configured
// word, counts the drops and closes each kept word with one space.
// ----------------------------------------------------------------------------
//   channel  direction  handshake            word
//   req      in         req_valid/req_stall  text byte, end of text flag
//   rsp      out        rsp_valid/rsp_stall  output byte or count report
//   csr      in         APB psel/penable     64-bit registers at 8*index
//
// A word byte is buffered in the cell row. Closing a kept word drains the row
// into the output register one byte per cycle while the output is not stalled,
// then adds one space; a dropped word closes with no output.
// End of text adds one count report.
// Overlong words drain the row once, then go through one byte per item.
// Synchronous active-high reset clears control state, count and registers.
// req_stall is high until every result of the accepted item is in the output
// register; rsp_stall holds the output.
// ----------------------------------------------------------------------------
module case_folding_word_filter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_text_byte,
   input  logic                        req_end_of_text,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_count_report,
   output logic [15:0]                 rsp_omitted_words,
   output logic                        rsp_last_of_run,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [cfw_pkg::PADDR_W-1:0] paddr,
   input  logic [cfw_pkg::PDATA_W-1:0] pwdata,
   output logic [cfw_pkg::PDATA_W-1:0] prdata,
   output logic                        pready
);
   import cfw_pkg::*;

   localparam logic [2:0] REG_WORD_LENGTH = 3'd0;
   localparam logic [2:0] REG_CHARS_A     = 3'd1;
   localparam logic [2:0] REG_CHARS_B     = 3'd2;
   localparam logic [2:0] REG_CHARS_C     = 3'd3;
   localparam logic [2:0] REG_CHARS_D     = 3'd4;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DRAIN  = 3'd1;
   localparam logic [2:0] ST_BYTE   = 3'd2;
   localparam logic [2:0] ST_SPACE  = 3'd3;
   localparam logic [2:0] ST_REPORT = 3'd4;

   // configuration registers
   logic [4:0]  word_length_ff;
   logic [63:0] chars_a_ff, chars_b_ff, chars_c_ff;
   logic [47:0] chars_d_ff;
   logic [2:0]  reg_idx;
   logic        csr_write;
   logic [CFG_BITS-1:0] cfg_chars;

   assign pready    = 1'b1;
   assign reg_idx   = paddr[5:3];
   assign csr_write = psel && penable && pwrite && pready;
   assign cfg_chars = {chars_d_ff, chars_c_ff, chars_b_ff, chars_a_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         word_length_ff <= '0;
         chars_a_ff     <= '0;
         chars_b_ff     <= '0;
         chars_c_ff     <= '0;
         chars_d_ff     <= '0;
      end else if (csr_write) begin
         case (reg_idx)
            REG_WORD_LENGTH: word_length_ff <= pwdata[4:0];
            REG_CHARS_A:     chars_a_ff     <= pwdata;
            REG_CHARS_B:     chars_b_ff     <= pwdata;
            REG_CHARS_C:     chars_c_ff     <= pwdata;
            REG_CHARS_D:     chars_d_ff     <= pwdata[47:0];
            default: ;
         endcase
      end
   end

   // register read back
   always_comb begin
      case (reg_idx)
         REG_WORD_LENGTH: prdata = PDATA_W'(word_length_ff);
         REG_CHARS_A:     prdata = chars_a_ff;
         REG_CHARS_B:     prdata = chars_b_ff;
         REG_CHARS_C:     prdata = chars_c_ff;
         REG_CHARS_D:     prdata = PDATA_W'(chars_d_ff);
         default:         prdata = '0;
      endcase
   end

   // control state
   logic [2:0]       state_ff, state_in;
   logic [2:0]       after_ff, after_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             match_ff, match_in;
   logic             pass_ff, pass_in;
   logic             in_word_ff, in_word_in;
   logic             eot_ff, eot_in;
   logic [7:0]       hold_byte_ff, hold_byte_in;
   logic [15:0]      count_ff, count_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_report_ff, rsp_report_in;
   logic [15:0] rsp_omitted_ff, rsp_omitted_in;
   logic        rsp_last_ff, rsp_last_in;

   logic         accept, out_free, sep, word_hit, char_hit, len_full;
   logic         emit, emit_report, emit_last;
   logic [7:0]   emit_byte;
   cell_ctl_type ctl;
   logic [7:0]   head_data;
   logic         head_valid, second_valid;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign sep       = is_sep(req_text_byte);
   assign len_full  = (len_ff == LEN_W'(MAX_WORD));
   assign word_hit  = (word_length_ff != 5'd0) && match_ff &&
                      (CMP_W'(len_ff) == CMP_W'(word_length_ff));
   assign char_hit  = ((req_text_byte | FOLD_BIT) ==
                       (cfg_char(cfg_chars, len_ff) | FOLD_BIT));

   cfw_word_chain u_chain (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .text_byte    (req_text_byte),
      .head_data    (head_data),
      .head_valid   (head_valid),
      .second_valid (second_valid)
   );

   // sequencer: buffer, drop or drain words, then space and count report
   always_comb begin
      state_in     = state_ff;
      after_in     = after_ff;
      len_in       = len_ff;
      match_in     = match_ff;
      pass_in      = pass_ff;
      in_word_in   = in_word_ff;
      eot_in       = eot_ff;
      hold_byte_in = hold_byte_ff;
      count_in     = count_ff;
      ctl          = '0;
      emit         = 1'b0;
      emit_byte    = '0;
      emit_report  = 1'b0;
      emit_last    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               eot_in       = req_end_of_text;
               hold_byte_in = req_text_byte;
               if (req_end_of_text || sep) begin
                  if (req_end_of_text || in_word_ff) begin
                     pass_in    = 1'b0;
                     in_word_in = 1'b0;
                     len_in     = '0;
                     if (pass_ff) begin
                        state_in = ST_SPACE;
                     end else if (len_ff != '0) begin
                        if (word_hit) begin
                           ctl.clear = 1'b1;
                           if (count_ff != 16'hffff) begin
                              count_in = count_ff + 16'd1;
                           end
                           state_in = req_end_of_text ? ST_REPORT : ST_IDLE;
                        end else begin
                           state_in = ST_DRAIN;
                           after_in = ST_SPACE;
                        end
                     end else begin
                        state_in = req_end_of_text ? ST_REPORT : ST_IDLE;
                     end
                  end
               end else begin
                  in_word_in = 1'b1;
                  if (pass_ff) begin
                     state_in = ST_BYTE;
                  end else if (!len_full) begin
                     ctl.append = 1'b1;
                     len_in     = len_ff + LEN_W'(1);
                     match_in   = ((len_ff == '0) || match_ff) && char_hit;
                  end else begin
                     state_in = ST_DRAIN;
                     after_in = ST_BYTE;
                     len_in   = '0;
                     pass_in  = 1'b1;
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = head_data;
               ctl.shift = 1'b1;
               if (!second_valid) begin
                  state_in = after_ff;
               end
            end
         end
         ST_BYTE: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = hold_byte_ff;
               emit_last = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_SPACE: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = SPACE_BYTE;
               emit_last = !eot_ff;
               state_in  = eot_ff ? ST_REPORT : ST_IDLE;
            end
         end
         ST_REPORT: begin
            if (out_free) begin
               emit        = 1'b1;
               emit_report = 1'b1;
               emit_last   = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output word register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_byte_in    = rsp_byte_ff;
      rsp_report_in  = rsp_report_ff;
      rsp_omitted_in = rsp_omitted_ff;
      rsp_last_in    = rsp_last_ff;
      if (emit) begin
         rsp_valid_in   = 1'b1;
         rsp_byte_in    = emit_byte;
         rsp_report_in  = emit_report;
         rsp_omitted_in = count_ff;
         rsp_last_in    = emit_last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         after_ff     <= ST_IDLE;
         len_ff       <= '0;
         match_ff     <= 1'b0;
         pass_ff      <= 1'b0;
         in_word_ff   <= 1'b0;
         eot_ff       <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         after_ff     <= after_in;
         len_ff       <= len_in;
         match_ff     <= match_in;
         pass_ff      <= pass_in;
         in_word_ff   <= in_word_in;
         eot_ff       <= eot_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_byte_ff   <= hold_byte_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_report_ff  <= rsp_report_in;
      rsp_omitted_ff <= rsp_omitted_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = rsp_byte_ff;
   assign rsp_count_report  = rsp_report_ff;
   assign rsp_omitted_words = rsp_omitted_ff;
   assign rsp_last_of_run   = rsp_last_ff;

   // a draining word always has a byte at the head of the row
   a_drain_has_head: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |-> head_valid)
      else $error("drain with empty cell row");

   // pass-through mode never keeps buffered bytes
   a_pass_empty: assert property (@(posedge clock) disable iff (reset)
      pass_ff |-> (len_ff == '0))
      else $error("buffered bytes during pass-through");

   // the omission count only grows
   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> count_ff >= $past(count_ff))
      else $error("omission count went down");

   // a count report always closes its run
   a_report_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_report_ff |-> rsp_last_ff)
      else $error("count report not last of run");

endmodule

@@ rtl/cfw_cell.sv @@
// ----------------------------------------------------------------------------
// cfw_cell
// One byte slot of the word row: fills in order, shifts toward the head.
// ----------------------------------------------------------------------------
module cfw_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  cfw_pkg::cell_ctl_type ctl,
   input  logic [7:0]            text_byte,
   input  logic                  prev_valid,
   input  logic [7:0]            next_data,
   input  logic                  next_valid,
   output logic [7:0]            data,
   output logic                  valid
);
   import cfw_pkg::*;

   logic [7:0] data_ff, data_in;
   logic       valid_ff, valid_in;

   // clear drops the word, shift moves toward the head, append fills first free slot
   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.shift) begin
         data_in  = next_data;
         valid_in = next_valid;
      end else if (ctl.append && !valid_ff && prev_valid) begin
         data_in  = text_byte;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data  = data_ff;
   assign valid = valid_ff;

endmodule

@@ rtl/cfw_word_chain.sv @@
// ----------------------------------------------------------------------------
// cfw_word_chain
// Row of byte cells holding the pending word, head at cell zero.
// ----------------------------------------------------------------------------
module cfw_word_chain (
   input  logic                  clock,
   input  logic                  reset,
   input  cfw_pkg::cell_ctl_type ctl,
   input  logic [7:0]            text_byte,
   output logic [7:0]            head_data,
   output logic                  head_valid,
   output logic                  second_valid
);
   import cfw_pkg::*;

   logic [7:0] data_w  [0:MAX_WORD];
   logic       valid_w [0:MAX_WORD];

   // empty slot past the tail
   assign data_w[MAX_WORD]  = '0;
   assign valid_w[MAX_WORD] = 1'b0;

   for (genvar i = 0; i < MAX_WORD; i++) begin : g_cell
      logic prev_valid;
      if (i == 0) begin : g_head
         assign prev_valid = 1'b1;
      end else begin : g_body
         assign prev_valid = valid_w[i-1];
      end
      cfw_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .text_byte  (text_byte),
         .prev_valid (prev_valid),
         .next_data  (data_w[i+1]),
         .next_valid (valid_w[i+1]),
         .data       (data_w[i]),
         .valid      (valid_w[i])
      );
   end

   assign head_data    = data_w[0];
   assign head_valid   = valid_w[0];
   assign second_valid = valid_w[1];

endmodule

@@ tb/word_filter_checker.sv @@
// ----------------------------------------------------------------------------
// word_filter_checker
// Watches the text, result and register ports of the case folding word
// filter, keeps its own model of the filter state, predicts every result
// word and compares each field against what the block returns.
// ----------------------------------------------------------------------------
package word_filter_tb_pkg;

   // register indexes, one 64-bit register every 8 bytes
   typedef enum logic [2:0] {
      CSR_WORD_LENGTH,
      CSR_CHARS_A,
      CSR_CHARS_B,
      CSR_CHARS_C,
      CSR_CHARS_D
   } csr_index_type;

   // space, tab, newline, vtab, formfeed, return
   function automatic bit is_blank(input logic [7:0] b);
      return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0d);
   endfunction

endpackage

module word_filter_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [7:0]                  req_text_byte,
   input  logic                        req_end_of_text,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [7:0]                  rsp_out_byte,
   input  logic                        rsp_count_report,
   input  logic [15:0]                 rsp_omitted_words,
   input  logic                        rsp_last_of_run,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic                        pready,
   input  logic [cfw_pkg::PADDR_W-1:0] paddr,
   input  logic [cfw_pkg::PDATA_W-1:0] pwdata,
   output int                          fail_count,
   output int                          pending
);
   import cfw_pkg::*;
   import word_filter_tb_pkg::*;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        count_report;
      logic [15:0] omitted_words;
      logic        last_of_run;
   } filter_result_type;

   // configured word
   logic [4:0]          cfg_length = '0;
   logic [CFG_BITS-1:0] cfg_chars  = '0;

   // filter state
   logic [7:0]  held_word [MAX_WORD];
   int          held_len   = 0;
   bit          passing    = 1'b0;
   bit          in_word    = 1'b0;
   logic [15:0] omit_count = '0;

   filter_result_type filtered_text_q [$];
   filter_result_type step_q [$];
   filter_result_type got;
   filter_result_type want;
   int                errors = 0;

   // buffered word equals the configured one, case folded
   function automatic bit held_word_hits();
      if (cfg_length == 0 || held_len != int'(cfg_length)) return 1'b0;
      for (int i = 0; i < held_len; i++) begin
         if ((held_word[i] | 8'h20) != (cfg_chars[i*8 +: 8] | 8'h20)) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void emit(input logic [7:0] b, input bit report);
      step_q.push_back('{b, report, 16'h0, 1'b0});
   endfunction

   // close the pending word: drop and count it, or send it with a space
   function automatic void close_word();
      if (passing) begin
         emit(8'h20, 1'b0);
      end else if (held_len > 0) begin
         if (held_word_hits()) begin
            if (omit_count != 16'hffff) omit_count++;
         end else begin
            for (int i = 0; i < held_len; i++) emit(held_word[i], 1'b0);
            emit(8'h20, 1'b0);
         end
      end
      held_len = 0;
      passing  = 1'b0;
      in_word  = 1'b0;
   endfunction

   // results caused by one accepted text word
   function automatic void filter_text_byte(input logic [7:0] b, input bit eot);
      step_q.delete();
      if (eot) begin
         close_word();
         emit(8'h00, 1'b1);
      end else if (is_blank(b)) begin
         if (in_word) close_word();
      end else begin
         in_word = 1'b1;
         if (passing) begin
            emit(b, 1'b0);
         end else if (held_len < MAX_WORD) begin
            held_word[held_len] = b;
            held_len++;
         end else begin
            // overlong word: flush the buffer and go straight through
            for (int i = 0; i < held_len; i++) emit(held_word[i], 1'b0);
            emit(b, 1'b0);
            held_len = 0;
            passing  = 1'b1;
         end
      end
      foreach (step_q[k]) begin
         step_q[k].omitted_words = omit_count;
         step_q[k].last_of_run   = (k == step_q.size() - 1);
         filtered_text_q.push_back(step_q[k]);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg_length = '0;
         cfg_chars  = '0;
         held_len   = 0;
         passing    = 1'b0;
         in_word    = 1'b0;
         omit_count = '0;
         filtered_text_q.delete();
      end else begin
         // register writes
         if (psel && penable && pwrite && pready) begin
            case (csr_index_type'(paddr[PADDR_W-1:3]))
               CSR_WORD_LENGTH: cfg_length = pwdata[4:0];
               CSR_CHARS_A:     cfg_chars[63:0]    = pwdata;
               CSR_CHARS_B:     cfg_chars[127:64]  = pwdata;
               CSR_CHARS_C:     cfg_chars[191:128] = pwdata;
               CSR_CHARS_D:     cfg_chars[239:192] = pwdata[47:0];
               default: ;
            endcase
         end

         if (req_valid && !req_stall) filter_text_byte(req_text_byte, req_end_of_text);

         // compare each accepted result with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_out_byte, rsp_count_report, rsp_omitted_words, rsp_last_of_run};
            if (filtered_text_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected result: byte %02h report %0b count %0d last %0b",
                           got.out_byte, got.count_report, got.omitted_words,
                           got.last_of_run);
            end else begin
               want = filtered_text_q.pop_front();
               if (got.out_byte !== want.out_byte
                   || got.count_report !== want.count_report
                   || got.omitted_words !== want.omitted_words
                   || got.last_of_run !== want.last_of_run) begin
                  errors++;
                  if (errors <= 10)
                     $display({"result mismatch: expected byte %02h report %0b count %0d ",
                               "last %0b, got byte %02h report %0b count %0d last %0b"},
                              want.out_byte, want.count_report, want.omitted_words,
                              want.last_of_run, got.out_byte, got.count_report,
                              got.omitted_words, got.last_of_run);
               end
            end
         end
      end
      pending    = filtered_text_q.size();
      fail_count = errors;
   end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives text words and register writes into the case folding word filter
// with random sender gaps and receiver stalls; the checker beside the block
// predicts and compares every result. Covers directed corner words, random
// phases over several configured words, overlong words and a one-byte word.
// ----------------------------------------------------------------------------
module testbench;
   import cfw_pkg::*;
   import word_filter_tb_pkg::*;

   localparam logic [7:0] BLANKS [6] = '{8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};

   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_stall;
   logic [7:0]         req_text_byte   = '0;
   logic               req_end_of_text = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall       = 1'b0;
   logic [7:0]         rsp_out_byte;
   logic               rsp_count_report;
   logic [15:0]        rsp_omitted_words;
   logic               rsp_last_of_run;
   logic               psel            = 1'b0;
   logic               penable         = 1'b0;
   logic               pwrite          = 1'b0;
   logic [PADDR_W-1:0] paddr           = '0;
   logic [PDATA_W-1:0] pwdata          = '0;
   logic [PDATA_W-1:0] prdata;
   logic               pready;

   int fail_count;
   int pending;

   // stimulus state
   int          cfg_len     = 0;
   logic [239:0] cfg_word   = '0;
   logic [7:0]  word_q [$];
   int          items_sent  = 0;
   int          burst_left  = 0;

   // receiver stall pattern
   int          stall_mode  = 0;
   int          stall_left  = 0;
   logic [2:0]  stall_phase = '0;

   case_folding_word_filter u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_text_byte     (req_text_byte),
      .req_end_of_text   (req_end_of_text),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_count_report  (rsp_count_report),
      .rsp_omitted_words (rsp_omitted_words),
      .rsp_last_of_run   (rsp_last_of_run),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   word_filter_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_text_byte     (req_text_byte),
      .req_end_of_text   (req_end_of_text),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_count_report  (rsp_count_report),
      .rsp_omitted_words (rsp_omitted_words),
      .rsp_last_of_run   (rsp_last_of_run),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .pready            (pready),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   always #10 clock = ~clock;

   // receiver: stretches of no stall, random stall, rare stall, periodic stall
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(16, 96);
      end else begin
         stall_left <= stall_left - 1;
      end
      stall_phase <= stall_phase + 3'd1;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 1) == 1);
         2: rsp_stall <= ($urandom_range(0, 7) == 0);
         default: rsp_stall <= (stall_phase >= 3'd3);
      endcase
   end

   // one text word, sent in bursts with random gaps
   task automatic send_item(input logic [7:0] b, input logic eot);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 8);
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_valid       <= 1'b1;
      req_text_byte   <= b;
      req_end_of_text <= eot;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      burst_left--;
      items_sent++;
   endtask

   // hold off until every predicted result has come out
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // setup then access phase; psel stays up across back-to-back writes
   task automatic csr_write(input csr_index_type idx, input logic [63:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
   endtask

   // load all five registers; spare upper bits carry noise
   task automatic set_word(input int len, input logic [239:0] chars);
      logic [63:0] v;
      cfg_len  = len;
      cfg_word = chars;
      v        = {$urandom(), $urandom()};
      v[4:0]   = len[4:0];
      csr_write(CSR_WORD_LENGTH, v);
      csr_write(CSR_CHARS_A, chars[63:0]);
      csr_write(CSR_CHARS_B, chars[127:64]);
      csr_write(CSR_CHARS_C, chars[191:128]);
      v        = {$urandom(), $urandom()};
      v[47:0]  = chars[239:192];
      csr_write(CSR_CHARS_D, v);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   function automatic logic [7:0] word_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (is_blank(b));
      return b;
   endfunction

   // either case variant of a configured character that is not a blank
   function automatic logic [7:0] fold_variant(input logic [7:0] c);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = c & 8'hdf;
      hi = c | 8'h20;
      if (is_blank(lo)) return hi;
      if (is_blank(hi)) return lo;
      return $urandom_range(0, 1) ? hi : lo;
   endfunction

   function automatic logic [239:0] random_chars();
      logic [255:0] w;
      for (int i = 0; i < 8; i++) w[i*32 +: 32] = $urandom();
      return w[239:0];
   endfunction

   function automatic logic [239:0] letter_chars();
      logic [239:0] w;
      for (int i = 0; i < 30; i++) w[i*8 +: 8] = word_byte();
      return w;
   endfunction

   // random words, matches, near misses, overlong words, text ends and noise
   task automatic run_phase(input int n_items);
      int         first;
      int         kind;
      int         n;
      int         j;
      logic [7:0] nb;
      first = items_sent;
      while (items_sent - first < n_items) begin
         kind = $urandom_range(0, 99);
         word_q.delete();
         if (kind >= 90) begin
            send_item(8'($urandom_range(0, 255)), 1'b0);
         end else if (kind >= 82) begin
            send_item(8'($urandom_range(0, 255)), 1'b1);
         end else begin
            if (kind < 50 && cfg_len >= 1 && cfg_len <= 30) begin
               for (int i = 0; i < cfg_len; i++)
                  word_q.push_back(fold_variant(cfg_word[i*8 +: 8]));
               // near miss: one folded character off, or one too short or long
               if (kind >= 35) begin
                  case ($urandom_range(0, 2))
                     0: begin
                        j = $urandom_range(0, cfg_len - 1);
                        do nb = word_byte(); while ((nb | 8'h20) == (word_q[j] | 8'h20));
                        word_q[j] = nb;
                     end
                     1: if (word_q.size() > 1) void'(word_q.pop_back());
                     default: word_q.push_back(word_byte());
                  endcase
               end
            end else if (kind >= 68) begin
               n = ($urandom_range(0, 2) == 0) ? 31 : $urandom_range(32, 45);
               repeat (n) word_q.push_back(word_byte());
            end else begin
               n = $urandom_range(1, 12);
               repeat (n) word_q.push_back(word_byte());
            end
            foreach (word_q[i]) send_item(word_q[i], 1'b0);
            n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2);
            repeat (n) send_item(BLANKS[$urandom_range(0, 5)], 1'b0);
         end
      end
      send_item(8'($urandom_range(0, 255)), 1'b1);
      drain_results();
   endtask

   // run limit
   initial begin
      #10_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset configuration: nothing matches, extreme bytes and every blank
      send_item(8'h00, 1'b0);
      send_item(8'h20, 1'b0);
      send_item(8'hff, 1'b0);
      send_item(8'h09, 1'b0);
      send_item(8'h7f, 1'b0);
      send_item(8'h0a, 1'b0);
      send_item(8'h0b, 1'b0);
      send_item(8'h0c, 1'b0);
      send_item(8'h0d, 1'b0);
      send_item(8'h41, 1'b1);
      drain_results();

      // word "aB@": case folding, '@' against '`', drop at text end
      set_word(3, 240'h40_42_61);
      send_item(8'h41, 1'b0);
      send_item(8'h62, 1'b0);
      send_item(8'h60, 1'b0);
      send_item(8'h20, 1'b0);
      send_item(8'h61, 1'b0);
      send_item(8'h62, 1'b0);
      send_item(8'h40, 1'b0);
      send_item(8'h78, 1'b0);
      send_item(8'h0d, 1'b0);
      send_item(8'h41, 1'b0);
      send_item(8'h42, 1'b0);
      send_item(8'h40, 1'b0);
      send_item(8'h00, 1'b1);
      send_item(8'hff, 1'b1);
      drain_results();

      // random phases over several configured words, extremes included
      set_word(30, letter_chars());
      run_phase(36);
      set_word(31, random_chars());
      run_phase(36);
      set_word(1, '1);
      run_phase(36);
      set_word($urandom_range(1, 29), random_chars());
      run_phase(36);
      set_word(30, random_chars());
      run_phase(36);
      set_word(0, random_chars());
      run_phase(36);

      // one-byte word that matches often
      set_word(1, 240'h71);
      run_phase(26);

      repeat (40) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
